// ===== rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants of the scaled 2bpp pixel fetch
// Holds the queue word, the live configuration and the grey lookup.
// ----------------------------------------------------------------------------
`default_nettype none
package lsp_pkg;

  localparam int MAX_OUTPUT_DIM = 4096;
  localparam int DIM_W          = 13;   // output size, clamped to MAX_OUTPUT_DIM
  localparam int COORD_W        = 12;
  localparam int PANEL_W        = 17;   // panel size (register + 1)
  localparam int PROD_W         = COORD_W + PANEL_W;
  localparam int QUOT_W         = 17;   // source coordinate stays below panel size
  localparam int REM_W          = 12;   // remainder stays below the output size
  localparam int DIV_STEPS      = QUOT_W;

  localparam logic [31:0] DRAM_BASE = 32'h0C00_0000;

  localparam logic OP_MAP    = 1'b0;
  localparam logic OP_EXPAND = 1'b1;

  localparam logic [2:0] REG_DMA_LOW  = 3'd0;
  localparam logic [2:0] REG_DMA_HIGH = 3'd1;
  localparam logic [2:0] REG_PANEL_W  = 3'd2;
  localparam logic [2:0] REG_PANEL_H  = 3'd3;
  localparam logic [2:0] REG_OUT_W    = 3'd4;
  localparam logic [2:0] REG_OUT_H    = 3'd5;
  localparam logic [2:0] REG_LCD_EN   = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0]   out_w;
    logic [DIM_W-1:0]   out_h;
    logic [PANEL_W-1:0] panel_w;
    logic [PANEL_W-1:0] panel_h;
    logic [31:0]        base;
    logic               lcd_en;
  } cfg_t;

  // One word of the queue between the front and the back.
  typedef struct packed {
    logic              op;
    logic              err;
    logic [1:0]        grey_idx;
    logic [PROD_W-1:0] num_x;
    logic [PROD_W-1:0] num_y;
  } work_t;

  function automatic logic [31:0] grey_lookup(input logic [1:0] idx);
    logic [31:0] g;
    case (idx)
      2'd0:    g = 32'hFF00_0000;
      2'd1:    g = 32'hFF55_5555;
      2'd2:    g = 32'hFFAA_AAAA;
      default: g = 32'hFFFF_FFFF;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lsp_front.sv =====
// ----------------------------------------------------------------------------
// lsp_front: input stage
// Accepts a word, checks the coordinate, forms the scaled numerators and
// picks the pixel out of a fetched byte.
// ----------------------------------------------------------------------------
`default_nettype none
module lsp_front import lsp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_opcode,
  input  wire logic [COORD_W-1:0] in_dest_x,
  input  wire logic [COORD_W-1:0] in_dest_y,
  input  wire logic [7:0]         in_packed_byte,
  input  wire logic [1:0]         in_pixel_lane,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output work_t                   q_word
);

  logic  valid_r;
  work_t word_r;
  work_t word_nxt;
  logic  [1:0] idx;

  assign in_ready = !valid_r || q_ready;
  assign q_valid  = valid_r;
  assign q_word   = word_r;

  always_comb begin
    case (in_pixel_lane)
      2'd0:    idx = in_packed_byte[7:6];
      2'd1:    idx = in_packed_byte[5:4];
      2'd2:    idx = in_packed_byte[3:2];
      default: idx = in_packed_byte[1:0];
    endcase
    word_nxt.op       = in_opcode;
    word_nxt.err      = ({1'b0, in_dest_x} >= cfg.out_w) || ({1'b0, in_dest_y} >= cfg.out_h);
    word_nxt.grey_idx = idx;
    word_nxt.num_x    = PROD_W'(in_dest_x * cfg.panel_w);
    word_nxt.num_y    = PROD_W'(in_dest_y * cfg.panel_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsp_fifo.sv =====
// ----------------------------------------------------------------------------
// lsp_fifo: two-entry queue between front and back
// Lets the front keep taking words while the back is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module lsp_fifo import lsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire work_t wr_word,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output work_t      rd_word
);

  work_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_word  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsp_back.sv =====
// ----------------------------------------------------------------------------
// lsp_back: divider pipeline and address stage
// Restoring division, one quotient bit per stage for both axes, then the
// row multiply and the address add into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lsp_back import lsp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   q_valid,
  output logic        q_ready,
  input  wire work_t  q_word,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [31:0] out_fetch_address,
  output logic [1:0]  out_source_lane,
  output logic [31:0] out_grey_bgra,
  output logic        out_coord_error
);

  typedef struct packed {
    logic              op;
    logic              err;
    logic [1:0]        grey_idx;
    logic [REM_W-1:0]  rem_x;
    logic [QUOT_W-1:0] shf_x;   // dividend bits shifting out, quotient shifting in
    logic [REM_W-1:0]  rem_y;
    logic [QUOT_W-1:0] shf_y;
  } stage_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] shf;
  } div_t;

  function automatic div_t div_step(input logic [REM_W-1:0] rem,
                                    input logic [QUOT_W-1:0] shf,
                                    input logic [DIM_W-1:0] dvs);
    logic [DIM_W-1:0] t;
    logic             ge;
    div_t             r;
    t     = {rem, shf[QUOT_W-1]};
    ge    = (t >= dvs);
    r.rem = ge ? REM_W'(t - dvs) : REM_W'(t);
    r.shf = {shf[QUOT_W-2:0], ge};
    return r;
  endfunction

  logic   adv;
  logic   v_r [DIV_STEPS+1];
  stage_t s_r [DIV_STEPS+1];

  logic        out_valid_r;
  logic [31:0] addr_r;
  logic [1:0]  lane_r;
  logic [31:0] grey_r;
  logic        err_r;
  stage_t      last;
  logic [31:0] addr_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign q_ready   = adv;
  assign out_valid = out_valid_r;
  assign out_fetch_address = addr_r;
  assign out_source_lane   = lane_r;
  assign out_grey_bgra     = grey_r;
  assign out_coord_error   = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[0].op       <= q_word.op;
      s_r[0].err      <= q_word.err;
      s_r[0].grey_idx <= q_word.grey_idx;
      s_r[0].rem_x    <= q_word.num_x[PROD_W-1:QUOT_W];
      s_r[0].shf_x    <= q_word.num_x[QUOT_W-1:0];
      s_r[0].rem_y    <= q_word.num_y[PROD_W-1:QUOT_W];
      s_r[0].shf_y    <= q_word.num_y[QUOT_W-1:0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    div_t dx;
    div_t dy;
    assign dx = div_step(s_r[k].rem_x, s_r[k].shf_x, cfg.out_w);
    assign dy = div_step(s_r[k].rem_y, s_r[k].shf_y, cfg.out_h);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_r[k+1].op       <= s_r[k].op;
        s_r[k+1].err      <= s_r[k].err;
        s_r[k+1].grey_idx <= s_r[k].grey_idx;
        s_r[k+1].rem_x    <= dx.rem;
        s_r[k+1].shf_x    <= dx.shf;
        s_r[k+1].rem_y    <= dy.rem;
        s_r[k+1].shf_y    <= dy.shf;
      end
    end
  end

  // After the last step the shift registers hold the source coordinates.
  assign last     = s_r[DIV_STEPS];
  assign addr_nxt = cfg.base
                  + 32'(last.shf_y * cfg.panel_w[PANEL_W-1:2])
                  + 32'(last.shf_x[QUOT_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (last.op == OP_EXPAND) begin
        addr_r <= 32'd0;
        lane_r <= 2'd0;
        err_r  <= 1'b0;
        grey_r <= grey_lookup(last.grey_idx);
      end else begin
        addr_r <= last.err ? 32'd0 : addr_nxt;
        lane_r <= last.err ? 2'd0 : last.shf_x[1:0];
        err_r  <= last.err;
        grey_r <= 32'd0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lcd_scaled_2bpp_pixel_fetch.sv =====
// ----------------------------------------------------------------------------
// lcd_scaled_2bpp_pixel_fetch: nearest-neighbor 2bpp pixel fetch
// Maps destination pixels to source byte addresses and expands fetched
// bytes to BGRA grey.
//
//   channel | direction | handshake            | word
//   in_     | input     | in_valid / in_ready  | opcode, dest_x/y, byte, lane
//   out_    | output    | out_valid/out_ready  | address, lane, grey, flags
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// One word enters per cycle while not stalled; each passes the input
// register, the queue, the divider load stage, 17 divider stages (one
// quotient bit each) and the address stage. A stalled output holds the back
// end; the two-word queue lets the front keep accepting until it fills.
// Synchronous reset empties all stages and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module lcd_scaled_2bpp_pixel_fetch import lsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [11:0] in_dest_x,
  input  wire logic [11:0] in_dest_y,
  input  wire logic [7:0]  in_packed_byte,
  input  wire logic [1:0]  in_pixel_lane,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_fetch_address,
  output logic [1:0]       out_source_lane,
  output logic [31:0]      out_grey_bgra,
  output logic             out_frame_on,
  output logic             out_coord_error
);

  logic [15:0] dma_low_r;
  logic [7:0]  dma_high_r;
  logic [15:0] panel_w_m1_r;
  logic [15:0] panel_h_m1_r;
  logic [12:0] out_w_r;
  logic [12:0] out_h_r;
  logic        lcd_en_r;
  cfg_t        cfg;

  logic  fq_valid;
  logic  fq_ready;
  work_t fq_word;
  logic  bq_valid;
  logic  bq_ready;
  work_t bq_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dma_low_r    <= 16'd0;
      dma_high_r   <= 8'd0;
      panel_w_m1_r <= 16'd479;
      panel_h_m1_r <= 16'd239;
      out_w_r      <= 13'd480;
      out_h_r      <= 13'd240;
      lcd_en_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DMA_LOW:  dma_low_r    <= cfg_wdata;
        REG_DMA_HIGH: dma_high_r   <= cfg_wdata[7:0];
        REG_PANEL_W:  panel_w_m1_r <= cfg_wdata;
        REG_PANEL_H:  panel_h_m1_r <= cfg_wdata;
        REG_OUT_W:    out_w_r      <= cfg_wdata[12:0];
        REG_OUT_H:    out_h_r      <= cfg_wdata[12:0];
        REG_LCD_EN:   lcd_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.out_w   = (out_w_r > DIM_W'(MAX_OUTPUT_DIM)) ? DIM_W'(MAX_OUTPUT_DIM) : out_w_r;
    cfg.out_h   = (out_h_r > DIM_W'(MAX_OUTPUT_DIM)) ? DIM_W'(MAX_OUTPUT_DIM) : out_h_r;
    cfg.panel_w = {1'b0, panel_w_m1_r} + 17'd1;
    cfg.panel_h = {1'b0, panel_h_m1_r} + 17'd1;
    cfg.base    = DRAM_BASE + {8'd0, dma_high_r, dma_low_r};
    cfg.lcd_en  = lcd_en_r;
  end

  assign out_frame_on = cfg.lcd_en;

  lsp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_dest_x      (in_dest_x),
    .in_dest_y      (in_dest_y),
    .in_packed_byte (in_packed_byte),
    .in_pixel_lane  (in_pixel_lane),
    .q_valid        (fq_valid),
    .q_ready        (fq_ready),
    .q_word         (fq_word)
  );

  lsp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_word  (fq_word),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_word  (bq_word)
  );

  lsp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_valid           (bq_valid),
    .q_ready           (bq_ready),
    .q_word            (bq_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fetch_address (out_fetch_address),
    .out_source_lane   (out_source_lane),
    .out_grey_bgra     (out_grey_bgra),
    .out_coord_error   (out_coord_error)
  );

endmodule
`default_nettype wire
